// ===== sv/mat_pkg.sv =====
// Shared types and constants for the mean adaptive threshold block.
// No dependencies; mat_cfg and the top level import this package.
package mat_pkg;

    // Default sizing of the frame and the window
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 8;

    // Largest pixel value: four channel bytes summed
    localparam int PIX_MAX = 1020;
    localparam int PIX_W   = 10;

    // Binarized output levels
    localparam logic [7:0] LEVEL_DARK   = 8'd0;
    localparam logic [7:0] LEVEL_BRIGHT = 8'd255;

    // Configuration port sizing
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    // Register reset values
    localparam logic [10:0] RST_FRAME_WIDTH   = 11'd1024;
    localparam logic [10:0] RST_FRAME_HEIGHT  = 11'd1024;
    localparam logic [3:0]  RST_WINDOW_RADIUS = 4'd1;
    localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd1;

    // Register indexes
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_WINDOW_RADIUS = 2'd2,
        REG_CHANNEL_COUNT = 2'd3
    } reg_idx_t;

    // Raw register contents handed from the register file to the datapath
    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [3:0]  window_radius;
        logic [2:0]  channel_count;
        logic        restart;
    } cfg_regs_t;

endpackage

// ===== sv/mat_pix_if.sv =====
// Input pixel channel: valid/ready handshake with mode and channel bytes.
// Depends on nothing.
interface mat_pix_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
    logic [7:0] chan_d;

    modport source (output valid, mode, chan_a, chan_b, chan_c, chan_d, input ready);
    modport sink   (input valid, mode, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

// ===== sv/mat_res_if.sv =====
// Result channel: valid/ready handshake with the binarized level.
// Depends on nothing.
interface mat_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_level;
    logic       frame_last;

    modport source (output valid, out_level, frame_last, input ready);
    modport sink   (input valid, out_level, frame_last, output ready);
endinterface

// ===== sv/mat_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module mat_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mat_cfg.sv =====
// APB register file for frame size, window radius and channel count.
// Depends on mat_pkg.
module mat_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mat_pkg::CFG_AW-1:0]  paddr,
    input  logic [mat_pkg::CFG_DW-1:0]  pwdata,
    output logic [mat_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output mat_pkg::cfg_regs_t          cfg
);
    import mat_pkg::*;

    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [3:0]  radius_reg;
    logic [2:0]  chans_reg;
    logic        restart_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // Take register writes; any write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_FRAME_WIDTH;
            height_reg  <= RST_FRAME_HEIGHT;
            radius_reg  <= RST_WINDOW_RADIUS;
            chans_reg   <= RST_CHANNEL_COUNT;
            restart_reg <= 1'b0;
        end
        else
        begin
            restart_reg <= wr_en;
            if (wr_en)
            begin
                case (idx)
                    REG_FRAME_WIDTH:   width_reg  <= pwdata[10:0];
                    REG_FRAME_HEIGHT:  height_reg <= pwdata[10:0];
                    REG_WINDOW_RADIUS: radius_reg <= pwdata[3:0];
                    REG_CHANNEL_COUNT: chans_reg  <= pwdata[2:0];
                    default:           width_reg  <= width_reg;
                endcase
            end
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_FRAME_WIDTH:   prdata = CFG_DW'(width_reg);
            REG_FRAME_HEIGHT:  prdata = CFG_DW'(height_reg);
            REG_WINDOW_RADIUS: prdata = CFG_DW'(radius_reg);
            REG_CHANNEL_COUNT: prdata = CFG_DW'(chans_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.frame_width   = width_reg;
    assign cfg.frame_height  = height_reg;
    assign cfg.window_radius = radius_reg;
    assign cfg.channel_count = chans_reg;
    assign cfg.restart       = restart_reg;

endmodule

// ===== sv/mean_adaptive_threshold.sv =====
// Top level: line-store ring in one RAM, sequencer that sums the window per result.
// Depends on mat_pkg, mat_pix_if, mat_res_if, mat_ram and mat_cfg.
//
//   channel   role    carries
//   pix       sink    mode, chan_a..chan_d (one pixel or drain item)
//   res       source  out_level, frame_last
//   apb       slave   frame_width, frame_height, window_radius, channel_count
//
// An item that yields no result leaves the sequencer idle. One that yields a result
// passes the accept, a scan step per window cell (a read through the single read port
// for each cell inside the frame), the centre read, the compare and the output load.
// Reset clears positions and control; the line store is not cleared.
// A result still waiting in the output register holds the sequencer in its
// last state, and the input with it; pix.ready is low while a write's restart is high.
module mean_adaptive_threshold #(
    parameter int MAX_WIDTH  = mat_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mat_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = mat_pkg::DEF_MAX_RADIUS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mat_pix_if.sink                    pix,
    mat_res_if.source                  res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mat_pkg::CFG_AW-1:0] paddr,
    input  logic [mat_pkg::CFG_DW-1:0] pwdata,
    output logic [mat_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import mat_pkg::*;

    localparam int RING  = 3 * MAX_RADIUS + 1;
    localparam int SLW   = $clog2(RING);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CW1   = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int DW    = $clog2(2 * MAX_RADIUS + 1);
    localparam int SIDE  = 2 * MAX_RADIUS + 1;
    localparam int CNW   = $clog2(SIDE * SIDE + 1);
    localparam int SW    = $clog2(SIDE * SIDE * PIX_MAX + 1);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int YS    = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1) + 1;
    localparam int XS    = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 1) + 1;
    localparam int TW    = SLW + 2;

    // Clamped register reset values
    localparam int RST_W = (int'(RST_FRAME_WIDTH) > MAX_WIDTH) ? MAX_WIDTH
                                                               : int'(RST_FRAME_WIDTH);
    localparam int RST_H = (int'(RST_FRAME_HEIGHT) > MAX_HEIGHT) ? MAX_HEIGHT
                                                                 : int'(RST_FRAME_HEIGHT);
    localparam int RST_R = (int'(RST_WINDOW_RADIUS) > MAX_RADIUS) ? MAX_RADIUS
                                                                  : int'(RST_WINDOW_RADIUS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CENTRE,
        ST_CALC,
        ST_FIN
    } state_t;

    cfg_regs_t cfg;

    // Configuration registers
    mat_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Clamp the raw registers
    logic [CW1-1:0] w_c;
    logic [YW-1:0]  h_c;
    logic [RW-1:0]  r_c;
    logic [2:0]     c_c;

    always_comb
    begin
        if (cfg.frame_width == 11'd0)
            w_c = CW1'(1);
        else if (32'(cfg.frame_width) > 32'(MAX_WIDTH))
            w_c = CW1'(MAX_WIDTH);
        else
            w_c = CW1'(cfg.frame_width);

        if (cfg.frame_height == 11'd0)
            h_c = YW'(1);
        else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT))
            h_c = YW'(MAX_HEIGHT);
        else
            h_c = YW'(cfg.frame_height);

        if (32'(cfg.window_radius) > 32'(MAX_RADIUS))
            r_c = RW'(MAX_RADIUS);
        else
            r_c = RW'(cfg.window_radius);

        if (cfg.channel_count == 3'd0)
            c_c = 3'd1;
        else if (cfg.channel_count > 3'd4)
            c_c = 3'd4;
        else
            c_c = cfg.channel_count;
    end

    logic [CW1-1:0] w_reg;
    logic [YW-1:0]  h_reg;
    logic [RW-1:0]  r_reg;
    logic [2:0]     c_reg;
    logic [PW-1:0]  total_reg;
    logic [PW-1:0]  lag_reg;

    // Hold derived frame figures
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg     <= CW1'(RST_W);
            h_reg     <= YW'(RST_H);
            r_reg     <= RW'(RST_R);
            c_reg     <= RST_CHANNEL_COUNT;
            total_reg <= PW'(RST_W * RST_H);
            lag_reg   <= PW'(RST_R * RST_W + RST_R);
        end
        else
        begin
            w_reg     <= w_c;
            h_reg     <= h_c;
            r_reg     <= r_c;
            c_reg     <= c_c;
            total_reg <= PW'(32'(w_c) * 32'(h_c));
            lag_reg   <= PW'(32'(r_c) * 32'(w_c) + 32'(r_c));
        end
    end

    state_t         state_reg;
    logic [XW-1:0]  in_col_reg;
    logic [YW-1:0]  in_row_reg;
    logic [SLW-1:0] in_slot_reg;
    logic [PW-1:0]  in_pos_reg;
    logic [XW-1:0]  out_col_reg;
    logic [YW-1:0]  out_row_reg;
    logic [SLW-1:0] out_slot_reg;
    logic [PW-1:0]  out_pos_reg;
    logic [DW-1:0]  dy_reg;
    logic [DW-1:0]  dx_reg;
    logic [SW-1:0]  sum_reg;
    logic [CNW-1:0] cnt_reg;
    logic           pend_reg;
    logic           lvl_bit_reg;
    logic           res_valid_reg;
    logic [7:0]     res_level_reg;
    logic           res_last_reg;

    // Input handshake and pixel value
    logic            accept;
    logic            in_done;
    logic [PIX_W-1:0] pix_val;
    logic            col_wrap;
    logic            done_next;
    logic [PW-1:0]   in_pos_next;
    logic            emit;

    // Hold off input while a register write restarts the frame
    assign pix.ready = (state_reg == ST_IDLE) && !cfg.restart;
    assign accept    = pix.valid && pix.ready;
    assign in_done   = (in_row_reg >= h_reg);
    assign col_wrap  = (CW1'(in_col_reg) + CW1'(1) >= w_reg);

    always_comb
    begin
        pix_val = PIX_W'(pix.chan_a);
        if (c_reg >= 3'd2)
            pix_val = pix_val + PIX_W'(pix.chan_b);
        if (c_reg >= 3'd3)
            pix_val = pix_val + PIX_W'(pix.chan_c);
        if (c_reg >= 3'd4)
            pix_val = pix_val + PIX_W'(pix.chan_d);
        if (pix.mode)
            pix_val = '0;
    end

    assign in_pos_next = in_done ? in_pos_reg : in_pos_reg + PW'(1);
    assign done_next   = in_done || (col_wrap && (in_row_reg + YW'(1) >= h_reg));
    assign emit        = done_next
                      || ((PW + 1)'(in_pos_next) > (PW + 1)'(out_pos_reg) + (PW + 1)'(lag_reg));

    // Window cell of the current scan step
    logic [YS-1:0]  yy;
    logic [XS-1:0]  xx;
    logic           cell_ok;
    logic [TW-1:0]  slot_t;
    logic [SLW-1:0] slot;
    logic           last_cell;

    assign yy = YS'(out_row_reg) + YS'(dy_reg) - YS'(r_reg);
    assign xx = XS'(out_col_reg) + XS'(dx_reg) - XS'(r_reg);
    assign cell_ok = !yy[YS-1] && (yy < YS'(h_reg)) && !xx[XS-1] && (xx < XS'(w_reg));

    always_comb
    begin
        slot_t = TW'(out_slot_reg) + TW'(dy_reg) + TW'(RING) - TW'(r_reg);
        if (slot_t >= TW'(2 * RING))
            slot_t = slot_t - TW'(2 * RING);
        else if (slot_t >= TW'(RING))
            slot_t = slot_t - TW'(RING);
        slot = SLW'(slot_t);
    end

    assign last_cell = (dy_reg == DW'(2 * r_reg)) && (dx_reg == DW'(2 * r_reg));

    // Line-store ring
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [PIX_W-1:0] ram_rdata;

    assign ram_we    = accept && !in_done;
    assign ram_waddr = AW'(32'(in_slot_reg) * 32'(MAX_WIDTH) + 32'(in_col_reg));

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = AW'(32'(slot) * 32'(MAX_WIDTH) + 32'(xx[XS-2:0]));
        case (state_reg)
            ST_SCAN:
            begin
                ram_re = cell_ok;
            end
            ST_CENTRE:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(32'(out_slot_reg) * 32'(MAX_WIDTH) + 32'(out_col_reg));
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    mat_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pix_val),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Compare centre times count against the window sum
    logic [PIX_W+CNW-1:0] prod;
    assign prod = (PIX_W + CNW)'(ram_rdata) * (PIX_W + CNW)'(cnt_reg);

    logic out_load;
    logic out_last;
    assign out_load = (state_reg == ST_FIN) && (!res_valid_reg || res.ready);
    assign out_last = (out_pos_reg + PW'(1) == total_reg);

    // Sequencer, positions and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            in_pos_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            out_pos_reg   <= '0;
            dy_reg        <= '0;
            dx_reg        <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            lvl_bit_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            res_level_reg <= LEVEL_DARK;
            res_last_reg  <= 1'b0;
        end
        else
        begin
            // Drop a taken result
            if (res.ready && !out_load)
                res_valid_reg <= 1'b0;

            // Accumulate the window read issued last cycle
            pend_reg <= (state_reg == ST_SCAN) && cell_ok;
            if (pend_reg)
                sum_reg <= sum_reg + SW'(ram_rdata);

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (!in_done)
                        begin
                            in_pos_reg <= in_pos_next;
                            if (col_wrap)
                            begin
                                in_col_reg <= '0;
                                in_row_reg <= in_row_reg + YW'(1);
                                if (in_slot_reg == SLW'(RING - 1))
                                    in_slot_reg <= '0;
                                else
                                    in_slot_reg <= in_slot_reg + SLW'(1);
                            end
                            else
                            begin
                                in_col_reg <= in_col_reg + XW'(1);
                            end
                        end
                        if (emit)
                        begin
                            state_reg <= ST_SCAN;
                            dy_reg    <= '0;
                            dx_reg    <= '0;
                            sum_reg   <= '0;
                            cnt_reg   <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (cell_ok)
                        cnt_reg <= cnt_reg + CNW'(1);
                    if (last_cell)
                        state_reg <= ST_CENTRE;
                    else if (dx_reg == DW'(2 * r_reg))
                    begin
                        dx_reg <= '0;
                        dy_reg <= dy_reg + DW'(1);
                    end
                    else
                    begin
                        dx_reg <= dx_reg + DW'(1);
                    end
                end
                ST_CENTRE:
                begin
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    lvl_bit_reg <= !((PIX_W + CNW + SW)'(prod) <= (PIX_W + CNW + SW)'(sum_reg));
                    state_reg   <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        res_valid_reg <= 1'b1;
                        res_level_reg <= lvl_bit_reg ? LEVEL_BRIGHT : LEVEL_DARK;
                        res_last_reg  <= out_last;
                        state_reg     <= ST_IDLE;
                        if (out_last)
                        begin
                            in_col_reg   <= '0;
                            in_row_reg   <= '0;
                            in_slot_reg  <= '0;
                            in_pos_reg   <= '0;
                            out_col_reg  <= '0;
                            out_row_reg  <= '0;
                            out_slot_reg <= '0;
                            out_pos_reg  <= '0;
                        end
                        else
                        begin
                            out_pos_reg <= out_pos_reg + PW'(1);
                            if (CW1'(out_col_reg) + CW1'(1) >= w_reg)
                            begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_reg + YW'(1);
                                if (out_slot_reg == SLW'(RING - 1))
                                    out_slot_reg <= '0;
                                else
                                    out_slot_reg <= out_slot_reg + SLW'(1);
                            end
                            else
                            begin
                                out_col_reg <= out_col_reg + XW'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Restart the frame on any register write
            if (cfg.restart)
            begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_slot_reg  <= '0;
                in_pos_reg   <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_slot_reg <= '0;
                out_pos_reg  <= '0;
            end
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.out_level  = res_level_reg;
    assign res.frame_last = res_last_reg;

`ifndef SYNTHESIS
    // The single RAM never writes and reads in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("line store written and read in one cycle");

    // The frame's last result returns both positions to zero
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_last |=> out_pos_reg == '0 && in_pos_reg == '0)
        else $error("positions not cleared after frame end");

    // The next result index stays inside the frame
    a_out_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> out_pos_reg < total_reg)
        else $error("result index beyond frame");
`endif

endmodule
